// File: hdl/cubic_bezier_point_eval_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cubic Bezier point evaluator
// Shared property forms clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH
`define CUBIC_BEZIER_POINT_EVAL_ASSERT_SVH

// Same-cycle implication.
`define CBPE_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("Same-cycle implication violated.");

// Next-cycle implication.
`define CBPE_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("Next-cycle implication violated.");

`endif

// File: hdl/cbpe_pkg.sv
// ----------------------------------------------------------------------------
// cbpe_pkg
// Types and constants shared by the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbpe_pkg;

	localparam int NUM_POINTS = 4;
	localparam int NUM_COMPS  = 4;
	localparam int REG_W      = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int PARAM_W    = 16;
	localparam int TU_W       = 15;
	localparam int FRAC_SHIFT = 42;
	localparam int NUM_STAGES = 8;

	localparam logic [TU_W-1:0] ONE_Q14 = 15'd16384;

	typedef struct packed {
		logic [TU_W-1:0] t;
		logic [TU_W-1:0] u;
	} tu_t;

	typedef struct packed {
		logic [NUM_STAGES:1] load;
		tu_t                 tu_s1;
		tu_t                 tu_s3;
		tu_t                 tu_s5;
	} pipe_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/cubic_bezier_point_eval.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// Four-component cubic Bezier point evaluator, one curve parameter per cycle while not stalled.
// ----------------------------------------------------------------------------
// The four control points are written through the configuration port, one
// 64-bit register per point, x in the low bits. Writes are to be made only
// while no request is in flight.
// Each request on the input channel carries a Q2.14 parameter t and produces
// exactly one point on the output channel. Parameters below 0 or above 1.0
// are clamped to the curve ends.
// The datapath has eight register stages: a parameter register, three de
// Casteljau levels of a multiply stage and an add stage each, the last add
// also rounding, and a saturating output register. A new request can enter
// on every cycle while in_stall is low.
// While the receiver stalls, the result is held and the empty stages behind
// it keep filling; the input stalls only once all eight stages are occupied.
// Reset clears the stage valid bits and the control points to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_point_eval #(
	parameter int COMPONENT_WIDTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_wr_en,
	input  wire logic [cbpe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [cbpe_pkg::REG_W-1:0]             cfg_data,
	input  wire logic                                   in_valid,
	output      logic                                   in_stall,
	input  wire logic signed [cbpe_pkg::PARAM_W-1:0]    curve_param,
	output      logic                                   out_valid,
	input  wire logic                                   out_stall,
	output      logic signed [COMPONENT_WIDTH-1:0]      out_x,
	output      logic signed [COMPONENT_WIDTH-1:0]      out_y,
	output      logic signed [COMPONENT_WIDTH-1:0]      out_z,
	output      logic signed [COMPONENT_WIDTH-1:0]      out_w
);

	localparam int ExtW = (cbpe_pkg::NUM_COMPS * COMPONENT_WIDTH > cbpe_pkg::REG_W) ?
		cbpe_pkg::NUM_COMPS * COMPONENT_WIDTH : cbpe_pkg::REG_W;

	logic [cbpe_pkg::REG_W-1:0]         point_q  [cbpe_pkg::NUM_POINTS];
	logic [ExtW-1:0]                    point_ext [cbpe_pkg::NUM_POINTS];
	logic signed [COMPONENT_WIDTH-1:0]  lane_res [cbpe_pkg::NUM_COMPS];
	cbpe_pkg::pipe_ctrl_t               ctrl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbpe_pkg::NUM_POINTS; i++) begin
				point_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			point_q[cfg_index] <= cfg_data;
		end
	end

	// Bits above the register read as zero for wide components.
	always_comb begin
		for (int i = 0; i < cbpe_pkg::NUM_POINTS; i++) begin
			point_ext[i] = ExtW'(point_q[i]);
		end
	end

	cbpe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.curve_param (curve_param),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ctrl        (ctrl)
	);

	for (genvar k = 0; k < cbpe_pkg::NUM_COMPS; k++) begin : g_lane
		cbpe_lane #(
			.CompW (COMPONENT_WIDTH)
		) u_lane (
			.clk    (clk),
			.ctrl   (ctrl),
			.p0     (signed'(point_ext[0][k*COMPONENT_WIDTH +: COMPONENT_WIDTH])),
			.p1     (signed'(point_ext[1][k*COMPONENT_WIDTH +: COMPONENT_WIDTH])),
			.p2     (signed'(point_ext[2][k*COMPONENT_WIDTH +: COMPONENT_WIDTH])),
			.p3     (signed'(point_ext[3][k*COMPONENT_WIDTH +: COMPONENT_WIDTH])),
			.result (lane_res[k])
		);
	end

	assign out_x = lane_res[0];
	assign out_y = lane_res[1];
	assign out_z = lane_res[2];
	assign out_w = lane_res[3];

	`include "cubic_bezier_point_eval_assert.svh"

	`CBPE_ASSERT_IMPLY(a_stall_needs_full_out, in_stall, out_valid && out_stall)
	`CBPE_ASSERT_IMPLY(a_drain_frees_input, out_valid && !out_stall, !in_stall)
	`CBPE_ASSERT_NEXT(a_full_keeps_result, in_stall, out_valid)

endmodule

`default_nettype wire

// File: hdl/cbpe_ctrl.sv
// ----------------------------------------------------------------------------
// cbpe_ctrl
// Pipeline control: stage valid bits, load enables and the clamped
// parameter pair (t, 1 - t) carried alongside the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbpe_ctrl (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output      logic                                   in_stall,
	input  wire logic signed [cbpe_pkg::PARAM_W-1:0]    curve_param,
	output      logic                                   out_valid,
	input  wire logic                                   out_stall,
	output      cbpe_pkg::pipe_ctrl_t                   ctrl
);

	logic [cbpe_pkg::NUM_STAGES:1]   valid_q;
	logic [cbpe_pkg::NUM_STAGES+1:1] load;
	cbpe_pkg::tu_t                   tu_in;
	cbpe_pkg::tu_t                   tu_s1, tu_s2, tu_s3, tu_s4, tu_s5;

	// A stage may load when it is empty or when its contents move on.
	always_comb begin
		load[cbpe_pkg::NUM_STAGES+1] = !out_stall;
		for (int i = cbpe_pkg::NUM_STAGES; i >= 1; i--) begin
			load[i] = !valid_q[i] || load[i+1];
		end
	end

	assign in_stall  = !load[1];
	assign out_valid = valid_q[cbpe_pkg::NUM_STAGES];

	// Out-of-range parameters clamp to the curve ends, which yields the end points exactly.
	always_comb begin
		priority if (curve_param[cbpe_pkg::PARAM_W-1]) begin
			tu_in.t = '0;
		end else if (curve_param[cbpe_pkg::PARAM_W-2:0] >
				{{(cbpe_pkg::PARAM_W-1-cbpe_pkg::TU_W){1'b0}}, cbpe_pkg::ONE_Q14}) begin
			tu_in.t = cbpe_pkg::ONE_Q14;
		end else begin
			tu_in.t = curve_param[cbpe_pkg::TU_W-1:0];
		end
		tu_in.u = cbpe_pkg::ONE_Q14 - tu_in.t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[1]) begin
				valid_q[1] <= in_valid;
			end
			for (int i = 2; i <= cbpe_pkg::NUM_STAGES; i++) begin
				if (load[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[1]) begin
			tu_s1 <= tu_in;
		end
		if (load[2]) begin
			tu_s2 <= tu_s1;
		end
		if (load[3]) begin
			tu_s3 <= tu_s2;
		end
		if (load[4]) begin
			tu_s4 <= tu_s3;
		end
		if (load[5]) begin
			tu_s5 <= tu_s4;
		end
	end

	assign ctrl.load  = load[cbpe_pkg::NUM_STAGES:1];
	assign ctrl.tu_s1 = tu_s1;
	assign ctrl.tu_s3 = tu_s3;
	assign ctrl.tu_s5 = tu_s5;

endmodule

`default_nettype wire

// File: hdl/cbpe_lane.sv
// ----------------------------------------------------------------------------
// cbpe_lane
// One component of the curve point by three de Casteljau levels, each a
// multiply stage and an add stage, then rounding and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbpe_lane #(
	parameter int CompW = 16
) (
	input  wire logic                        clk,
	input  wire cbpe_pkg::pipe_ctrl_t        ctrl,
	input  wire logic signed [CompW-1:0]     p0,
	input  wire logic signed [CompW-1:0]     p1,
	input  wire logic signed [CompW-1:0]     p2,
	input  wire logic signed [CompW-1:0]     p3,
	output      logic signed [CompW-1:0]     result
);

	localparam int MulW = CompW + cbpe_pkg::TU_W + 1;
	localparam int QW   = MulW + 1;
	localparam int M2W  = QW + cbpe_pkg::TU_W + 1;
	localparam int RW   = M2W + 1;
	localparam int M3W  = RW + cbpe_pkg::TU_W + 1;
	localparam int SW   = M3W + 1;
	localparam int QuoW = SW - cbpe_pkg::FRAC_SHIFT;

	localparam logic signed [SW-1:0] RoundBias =
		{{(SW-cbpe_pkg::FRAC_SHIFT){1'b0}}, 1'b1, {(cbpe_pkg::FRAC_SHIFT-1){1'b0}}};
	localparam logic signed [QuoW-1:0] QuoMax = QuoW'({1'b0, {(CompW-1){1'b1}}});
	localparam logic signed [QuoW-1:0] QuoMin = -QuoMax - QuoW'(1);

	logic signed [cbpe_pkg::TU_W:0] t1, u1, t3, u3, t5, u5;
	logic signed [MulW-1:0]         m_s2 [6];
	logic signed [QW-1:0]           q_s3 [3];
	logic signed [M2W-1:0]          n_s4 [4];
	logic signed [RW-1:0]           r_s5 [2];
	logic signed [M3W-1:0]          v_s6 [2];
	logic signed [SW-1:0]           sum_s7;
	logic signed [QuoW-1:0]         quo;
	logic signed [CompW-1:0]        result_s8;

	assign t1 = signed'({1'b0, ctrl.tu_s1.t});
	assign u1 = signed'({1'b0, ctrl.tu_s1.u});
	assign t3 = signed'({1'b0, ctrl.tu_s3.t});
	assign u3 = signed'({1'b0, ctrl.tu_s3.u});
	assign t5 = signed'({1'b0, ctrl.tu_s5.t});
	assign u5 = signed'({1'b0, ctrl.tu_s5.u});

	assign quo = signed'(sum_s7[SW-1:cbpe_pkg::FRAC_SHIFT]);

	always_ff @(posedge clk) begin
		if (ctrl.load[2]) begin
			m_s2[0] <= MulW'(u1) * MulW'(p0);
			m_s2[1] <= MulW'(t1) * MulW'(p1);
			m_s2[2] <= MulW'(u1) * MulW'(p1);
			m_s2[3] <= MulW'(t1) * MulW'(p2);
			m_s2[4] <= MulW'(u1) * MulW'(p2);
			m_s2[5] <= MulW'(t1) * MulW'(p3);
		end
		if (ctrl.load[3]) begin
			for (int j = 0; j < 3; j++) begin
				q_s3[j] <= QW'(m_s2[2*j]) + QW'(m_s2[2*j+1]);
			end
		end
		if (ctrl.load[4]) begin
			n_s4[0] <= M2W'(u3) * M2W'(q_s3[0]);
			n_s4[1] <= M2W'(t3) * M2W'(q_s3[1]);
			n_s4[2] <= M2W'(u3) * M2W'(q_s3[1]);
			n_s4[3] <= M2W'(t3) * M2W'(q_s3[2]);
		end
		if (ctrl.load[5]) begin
			r_s5[0] <= RW'(n_s4[0]) + RW'(n_s4[1]);
			r_s5[1] <= RW'(n_s4[2]) + RW'(n_s4[3]);
		end
		if (ctrl.load[6]) begin
			v_s6[0] <= M3W'(u5) * M3W'(r_s5[0]);
			v_s6[1] <= M3W'(t5) * M3W'(r_s5[1]);
		end
		if (ctrl.load[7]) begin
			sum_s7 <= SW'(v_s6[0]) + SW'(v_s6[1]) + RoundBias;
		end
		if (ctrl.load[8]) begin
			priority if (quo > QuoMax) begin
				result_s8 <= CompW'(QuoMax);
			end else if (quo < QuoMin) begin
				result_s8 <= CompW'(QuoMin);
			end else begin
				result_s8 <= CompW'(quo);
			end
		end
	end

	assign result = result_s8;

endmodule

`default_nettype wire
